// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and types for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Store geometry. The depth must be a power of two.
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 8;

    // Command codes carried by each input word.
    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_INSERT     = 3'd5,
        CMD_ERASE      = 3'd6
    } cmd_t;

    // Status codes returned with each result word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SH_RD,
        S_SH_WR,
        S_INS_FIN
    } state_t;

endpackage

// ===== rtl/core/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/double_ended_queue_ring.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_ring
// Bounded double-ended queue held in one circular RAM.
// ----------------------------------------------------------------------------
// A command word (cmd, value, position) is taken at a rising edge where start
// is high and busy is low. Each command yields exactly one result word
// (data_out, status, count), shown for one cycle with done high; the receiver
// cannot hold it off.
// Sequence from the accepting edge to done:
//   push back, push front, failed commands, code seven, insert at the count
//   and erase of the last element: done in the next cycle, no busy.
//   pop back, pop front, read: one RAM read, busy while in S_RD_WAIT.
//   insert or erase that moves elements: S_SH_RD then S_SH_WR for each
//   element that moves, insert closing in S_INS_FIN; each move is a RAM read
//   followed by a RAM write through the single read port and single write port.
// A new command may be accepted in the cycle the previous result is shown.
// Reset clears the head pointer, the element count and the sequencer; the
// RAM holds no reset and no clearing pass is needed, since only entries
// holding elements are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_ring
    import deq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            cmd,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [POS_W-1:0]      position,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [1:0]            status,
    output logic [CNT_W-1:0]      count
);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO        = CNT_W'(2);

    // Control state.
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                done_reg, done_next;

    // Working registers of a shift.
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  ins_reg, ins_next;

    // Result registers.
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    status_t               status_reg, status_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // RAM port signals.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0] pos_ext;
    cmd_t             cmd_in;

    assign pos_ext = CNT_W'(position);
    assign cmd_in  = cmd_t'(cmd);

    // Physical slot of a logical index; wraps because the depth is a power of two.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  logical);
        return head + logical[ADDR_W-1:0];
    endfunction

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ins_reg    <= ins_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    // Sequencer: command decode, RAM access and result formation.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        ins_next    = ins_reg;
        done_next   = 1'b0;
        data_next   = '0;
        status_next = ST_OK;
        count_next  = fill_reg;
        ram_we      = 1'b0;
        ram_waddr   = slot_of(head_reg, idx_reg);
        ram_wdata   = ram_rdata;
        ram_raddr   = slot_of(head_reg, idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (cmd_in)
                        CMD_PUSH_BACK:
                        begin
                            if (fill_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_of(head_reg, fill_reg);
                                ram_wdata  = value;
                                fill_next  = fill_reg + ONE;
                                count_next = fill_reg + ONE;
                            end
                        end
                        CMD_PUSH_FRONT:
                        begin
                            if (fill_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = head_reg - ADDR_W'(1);
                                ram_wdata  = value;
                                head_next  = head_reg - ADDR_W'(1);
                                fill_next  = fill_reg + ONE;
                                count_next = fill_reg + ONE;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = slot_of(head_reg, fill_reg - ONE);
                                fill_next  = fill_reg - ONE;
                                done_next  = 1'b0;
                                state_next = S_RD_WAIT;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                head_next  = head_reg + ADDR_W'(1);
                                fill_next  = fill_reg - ONE;
                                done_next  = 1'b0;
                                state_next = S_RD_WAIT;
                            end
                        end
                        CMD_READ:
                        begin
                            if (pos_ext >= fill_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = slot_of(head_reg, pos_ext);
                                done_next  = 1'b0;
                                state_next = S_RD_WAIT;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (pos_ext > fill_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (fill_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (fill_reg > pos_ext)
                            begin
                                // Elements behind the position move back first.
                                idx_next   = fill_reg;
                                pos_next   = pos_ext;
                                val_next   = value;
                                ins_next   = 1'b1;
                                done_next  = 1'b0;
                                state_next = S_SH_RD;
                            end
                            else
                            begin
                                // Insert at the count appends at the back.
                                ram_we     = 1'b1;
                                ram_waddr  = slot_of(head_reg, pos_ext);
                                ram_wdata  = value;
                                fill_next  = fill_reg + ONE;
                                count_next = fill_reg + ONE;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (pos_ext >= fill_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if ((pos_ext + ONE) < fill_reg)
                            begin
                                idx_next   = pos_ext;
                                pos_next   = pos_ext;
                                ins_next   = 1'b0;
                                done_next  = 1'b0;
                                state_next = S_SH_RD;
                            end
                            else
                            begin
                                // Erasing the last element needs no move.
                                fill_next  = fill_reg - ONE;
                                count_next = fill_reg - ONE;
                            end
                        end
                        default:
                        begin
                            // Unused code: no change, status ok.
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                done_next  = 1'b1;
                data_next  = ram_rdata;
                state_next = S_IDLE;
            end
            S_SH_RD:
            begin
                // Fetch the neighbor that moves into the current index.
                ram_raddr  = ins_reg ? slot_of(head_reg, idx_reg - ONE)
                                     : slot_of(head_reg, idx_reg + ONE);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                if (ins_reg)
                begin
                    idx_next   = idx_reg - ONE;
                    state_next = ((idx_reg - ONE) > pos_reg) ? S_SH_RD : S_INS_FIN;
                end
                else
                begin
                    idx_next = idx_reg + ONE;
                    if ((idx_reg + TWO) < fill_reg)
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        fill_next  = fill_reg - ONE;
                        count_next = fill_reg - ONE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_INS_FIN:
            begin
                // The gap is open; place the new element.
                ram_we     = 1'b1;
                ram_waddr  = slot_of(head_reg, pos_reg);
                ram_wdata  = val_reg;
                fill_next  = fill_reg + ONE;
                count_next = fill_reg + ONE;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign data_out = data_reg;
    assign status   = status_reg;
    assign count    = count_reg;

endmodule

// ===== tb/double_ended_queue_ring_test.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_ring_test
// Drives command words into the ring-buffer deque and checks every result
// word against a mirror of the deque kept in the testbench. A directed
// opening covers empty, range and wrap cases. Random traffic then fills the
// store to full and drains it to empty, with sender gaps that vary by phase.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_test
    import deq_pkg::*;
();

    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int CYCLE_LIMIT         = 4_000_000;
    localparam int RANDOM_WORDS        = 1400;
    localparam int SETTLE_CYCLES       = 16;
    localparam int MAX_REPORTS         = 10;
    localparam int MAX_GAP             = 24;
    localparam int EDGE_STAY           = 6;
    localparam int MIXED_STRETCH       = 120;

    typedef struct {
        logic [DATA_WIDTH-1:0] data;
        status_t               st;
        logic [CNT_W-1:0]      cnt;
    } result_word_t;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } fill_mode_t;

    // Mirror of the deque contents; it predicts the result word of each
    // accepted command and checks the words that come back in order.
    class deque_mirror;
        logic [DATA_WIDTH-1:0] slots [DEPTH];
        logic [ADDR_W-1:0]     head;
        logic [CNT_W-1:0]      fill;
        result_word_t          expected_words [$];
        int                    failures;

        function new();
            head     = '0;
            fill     = '0;
            failures = 0;
        endfunction

        function logic [ADDR_W-1:0] slot_of(int idx);
            return head + ADDR_W'(idx);
        endfunction

        function void note_command(logic [2:0] c, logic [DATA_WIDTH-1:0] v,
                                   logic [POS_W-1:0] p);
            result_word_t r;
            int           i;
            r.data = '0;
            r.st   = ST_OK;
            case (c)
                CMD_PUSH_BACK:
                    if (fill == DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        slots[slot_of(fill)] = v;
                        fill++;
                    end
                CMD_PUSH_FRONT:
                    if (fill == DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        head = head - 1'b1;
                        slots[head] = v;
                        fill++;
                    end
                CMD_POP_BACK:
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        fill--;
                        r.data = slots[slot_of(fill)];
                    end
                CMD_POP_FRONT:
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.data = slots[head];
                        head = head + 1'b1;
                        fill--;
                    end
                CMD_READ:
                    if (p >= fill)
                        r.st = ST_RANGE;
                    else
                        r.data = slots[slot_of(p)];
                CMD_INSERT:
                    // The range check wins over the full check.
                    if (p > fill)
                        r.st = ST_RANGE;
                    else if (fill == DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        for (i = fill; i > p; i--)
                            slots[slot_of(i)] = slots[slot_of(i - 1)];
                        slots[slot_of(p)] = v;
                        fill++;
                    end
                CMD_ERASE:
                    if (p >= fill)
                        r.st = ST_RANGE;
                    else
                    begin
                        for (i = p; i + 1 < fill; i++)
                            slots[slot_of(i)] = slots[slot_of(i + 1)];
                        fill--;
                    end
                default:
                    ;
            endcase
            r.cnt = fill;
            expected_words.insert(expected_words.size(), r);
        endfunction

        function void check_word(logic [DATA_WIDTH-1:0] d, logic [1:0] s,
                                 logic [CNT_W-1:0] n);
            result_word_t e;
            if (expected_words.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: unexpected result word data=%h status=%0d count=%0d",
                             d, s, n);
                return;
            end
            e = expected_words[0];
            expected_words.delete(0);
            if (e.data !== d || e.st !== s || e.cnt !== n)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: exp data=%h st=%0d cnt=%0d, got data=%h st=%0d cnt=%0d",
                             e.data, e.st, e.cnt, d, s, n);
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic [2:0]            cmd      = '0;
    logic [DATA_WIDTH-1:0] value    = '0;
    logic [POS_W-1:0]      position = '0;
    logic                  busy;
    logic                  done;
    logic [DATA_WIDTH-1:0] data_out;
    logic [1:0]            status;
    logic [CNT_W-1:0]      count;
    int                    cycles   = 0;
    deque_mirror           mirror;

    double_ended_queue_ring u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .value    (value),
        .position (position),
        .done     (done),
        .data_out (data_out),
        .status   (status),
        .count    (count)
    );

    // Free-running clock.
    always #6 clk = ~clk;

    // Run guard against a hung sequencer.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("double_ended_queue_ring test failed");
            $finish;
        end
    end

    // Every strobed result word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_word(data_out, status, count);
    end

    // Presents one word, holds it until it is taken, then leaves a random gap.
    task automatic send_word(logic [2:0] c, logic [DATA_WIDTH-1:0] v,
                             logic [POS_W-1:0] p, int idle_pct);
        int gap;
        start    <= 1'b1;
        cmd      <= c;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.note_command(c, v, p);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Draws one random word; the mode tilts the mix toward filling,
    // draining, or an even spread of commands.
    function automatic void pick_word(fill_mode_t mode, int held,
                                      output logic [2:0] c,
                                      output logic [DATA_WIDTH-1:0] v,
                                      output logic [POS_W-1:0] p);
        cmd_t order [7] = '{CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_POP_BACK,
                            CMD_POP_FRONT, CMD_READ, CMD_INSERT, CMD_ERASE};
        int   grow_th   [7] = '{34, 62, 68, 73, 78, 96, 99};
        int   shrink_th [7] = '{5, 9, 39, 69, 77, 79, 99};
        int   mixed_th  [7] = '{14, 28, 42, 56, 70, 84, 98};
        int   th        [7];
        int   r;
        int   k;
        case (mode)
            MODE_GROW:   th = grow_th;
            MODE_SHRINK: th = shrink_th;
            default:     th = mixed_th;
        endcase
        r = $urandom_range(0, 99);
        c = CMD_UNUSED;
        for (k = 6; k >= 0; k--)
            if (r < th[k])
                c = order[k];

        // Data extremes show up now and then.
        k = $urandom_range(0, 15);
        if (k == 0)
            v = '0;
        else if (k == 1)
            v = '1;
        else
            v = $urandom;

        // Positions mostly land inside the held range.
        p = POS_W'($urandom);
        if (c == CMD_READ || c == CMD_ERASE)
        begin
            if (held > 0 && $urandom_range(0, 9) < 8)
                p = POS_W'($urandom_range(0, held - 1));
        end
        else if (c == CMD_INSERT)
        begin
            if ($urandom_range(0, 9) < 8)
                p = (held > 255) ? POS_W'($urandom_range(0, 255))
                                 : POS_W'($urandom_range(0, held));
        end
    endfunction

    // Stimulus sequence.
    initial
    begin
        fill_mode_t            mode;
        int                    edge_hits;
        int                    mixed_left;
        int                    phase;
        int                    n;
        int                    idle_pct [3];
        logic [2:0]            c;
        logic [DATA_WIDTH-1:0] v;
        logic [POS_W-1:0]      p;

        idle_pct = '{26, 63, 0};
        mirror = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed opening: empty store, range failures, unused code,
        // insert on empty and at the back, head wrap from a front push.
        send_word(CMD_POP_BACK,   '0,            8'd0,   idle_pct[0]);
        send_word(CMD_POP_FRONT,  '0,            8'd0,   idle_pct[0]);
        send_word(CMD_READ,       '0,            8'd0,   idle_pct[0]);
        send_word(CMD_ERASE,      '0,            8'd0,   idle_pct[0]);
        send_word(CMD_INSERT,     32'h1,         8'd1,   idle_pct[0]);
        send_word(CMD_UNUSED,     '1,            8'd255, idle_pct[0]);
        send_word(CMD_INSERT,     32'h1234_5678, 8'd0,   idle_pct[0]);
        send_word(CMD_PUSH_BACK,  '1,            8'd0,   idle_pct[0]);
        send_word(CMD_PUSH_FRONT, '0,            8'd255, idle_pct[0]);
        send_word(CMD_INSERT,     32'hA5A5_A5A5, 8'd3,   idle_pct[0]);
        send_word(CMD_INSERT,     32'h5A5A_5A5A, 8'd1,   idle_pct[0]);
        send_word(CMD_INSERT,     32'hDEAD_BEEF, 8'd255, idle_pct[0]);
        send_word(CMD_READ,       '0,            8'd0,   idle_pct[0]);
        send_word(CMD_READ,       '0,            8'd4,   idle_pct[0]);
        send_word(CMD_READ,       '0,            8'd5,   idle_pct[0]);
        send_word(CMD_READ,       '1,            8'd255, idle_pct[0]);
        send_word(CMD_ERASE,      '0,            8'd2,   idle_pct[0]);
        send_word(CMD_ERASE,      '0,            8'd255, idle_pct[0]);
        send_word(CMD_ERASE,      '0,            8'd3,   idle_pct[0]);
        send_word(CMD_POP_FRONT,  '0,            8'd0,   idle_pct[0]);
        send_word(CMD_POP_BACK,   '0,            8'd0,   idle_pct[0]);
        send_word(CMD_PUSH_BACK,  32'h8000_0001, 8'd255, idle_pct[0]);
        send_word(CMD_POP_BACK,   '1,            8'd128, idle_pct[0]);
        send_word(CMD_UNUSED,     '0,            8'd0,   idle_pct[0]);

        // Random traffic in three gap phases; the fill mode carries over
        // so that the store is driven to full and back to empty.
        mode       = MODE_MIXED;
        mixed_left = 60;
        edge_hits  = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            for (n = 0; n < RANDOM_WORDS / 3; n++)
            begin
                pick_word(mode, mirror.fill, c, v, p);
                send_word(c, v, p, idle_pct[phase]);
                case (mode)
                    MODE_GROW:
                        if (mirror.fill == DEPTH)
                        begin
                            edge_hits++;
                            if (edge_hits >= EDGE_STAY)
                            begin
                                mode      = MODE_SHRINK;
                                edge_hits = 0;
                            end
                        end
                    MODE_SHRINK:
                        if (mirror.fill == 0)
                        begin
                            edge_hits++;
                            if (edge_hits >= EDGE_STAY)
                            begin
                                mode       = MODE_MIXED;
                                mixed_left = MIXED_STRETCH;
                                edge_hits  = 0;
                            end
                        end
                    default:
                    begin
                        mixed_left--;
                        if (mixed_left <= 0)
                            mode = MODE_GROW;
                    end
                endcase
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for stray words.
        while (mirror.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mirror.failures == 0)
            $display("double_ended_queue_ring test passed");
        else
            $display("double_ended_queue_ring test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue_ring.sv
tb/double_ended_queue_ring_test.sv
